[hdl/bclp_pkg.sv]
package bclp_pkg;

    localparam int unsigned SCAN_INTERVAL_MS = 10;
    localparam int unsigned DEBOUNCE_TICKS   = 2;

    localparam int unsigned MS_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [MS_W-1:0] LONG_PRESS_MS_RST  = 16'd2000;
    localparam logic [MS_W-1:0] SHORT_PRESS_MS_RST = 16'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS_MS = 2'd2;

    localparam logic [3:0] EV_NONE   = 4'd0;
    localparam logic [3:0] EV_DOWN   = 4'd1;
    localparam logic [3:0] EV_UP     = 4'd2;
    localparam logic [3:0] EV_SINGLE = 4'd3;
    localparam logic [3:0] EV_DOUBLE = 4'd4;
    localparam logic [3:0] EV_MULTI  = 4'd5;
    localparam logic [3:0] EV_LSTART = 4'd6;
    localparam logic [3:0] EV_LHOLD  = 4'd7;
    localparam logic [3:0] EV_LUP    = 4'd8;

    typedef struct packed {
        logic            press_level;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] short_press_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic       long_release;
        logic [3:0] last_event;
        logic       level_seen;
    } result_t;

endpackage

[hdl/bclp_cfg_regs.sv]
module bclp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bclp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bclp_pkg::MS_W-1:0]      cfg_data,
    output bclp_pkg::cfg_t                 cfg
);

    bclp_pkg::cfg_t cfg_reg;
    bclp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bclp_pkg::CFG_PRESS_LEVEL:    cfg_next.press_level    = cfg_data[0];
                bclp_pkg::CFG_LONG_PRESS_MS:  cfg_next.long_press_ms  = cfg_data;
                bclp_pkg::CFG_SHORT_PRESS_MS: cfg_next.short_press_ms = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_level    <= 1'b0;
            cfg_reg.long_press_ms  <= bclp_pkg::LONG_PRESS_MS_RST;
            cfg_reg.short_press_ms <= bclp_pkg::SHORT_PRESS_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/bclp_in_reg.sv]
module bclp_in_reg (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic key_level,
    input  logic advance,
    output logic item_valid,
    output logic item_level
);

    logic valid_reg;
    logic valid_next;
    logic level_reg;
    logic level_next;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign level_next = (in_valid && in_ready) ? key_level : level_reg;
    assign item_valid = valid_reg;
    assign item_level = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

endmodule

[hdl/bclp_engine.sv]
module bclp_engine #(
    parameter int unsigned ScanIntervalMs = bclp_pkg::SCAN_INTERVAL_MS,
    parameter int unsigned DebounceTicks  = bclp_pkg::DEBOUNCE_TICKS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bclp_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic              level,
    output bclp_pkg::result_t result
);

    localparam int unsigned MsW   = bclp_pkg::MS_W;
    localparam int unsigned ProdW = MsW + $clog2(ScanIntervalMs + 1);
    localparam logic [ProdW-1:0] Scan    = ProdW'(ScanIntervalMs);
    localparam logic [1:0]       DbLimit = 2'(DebounceTicks);
    localparam logic [MsW-1:0]   CntMax  = {MsW{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_PRESSED,
        PH_RELEASE
    } phase_t;

    phase_t         phase_reg;
    phase_t         phase_next;
    logic [1:0]     debounce_reg;
    logic [1:0]     debounce_next;
    logic [MsW-1:0] hold_reg;
    logic [MsW-1:0] hold_next;
    logic [7:0]     click_reg;
    logic [7:0]     click_next;
    logic [MsW-1:0] gap_reg;
    logic [MsW-1:0] gap_next;
    logic [3:0]     recent_reg;
    logic [3:0]     recent_next;

    logic             act;
    logic [3:0]       ev;
    logic             lrel;
    logic [MsW-1:0]   gap_inc;
    logic [ProdW-1:0] gap_prod;
    logic [ProdW-1:0] held_prod;
    logic [ProdW-1:0] held_inc_prod;
    logic [ProdW-1:0] short_ext;
    logic [ProdW-1:0] long_ext;
    logic [1:0]       debounce_inc;

    assign act           = (level == cfg.press_level);
    assign gap_inc       = (gap_reg == CntMax) ? gap_reg : gap_reg + 1'b1;
    assign gap_prod      = ProdW'(gap_inc) * Scan;
    assign held_prod     = ProdW'(hold_reg) * Scan;
    assign held_inc_prod = held_prod + Scan;
    assign short_ext     = ProdW'(cfg.short_press_ms);
    assign long_ext      = ProdW'(cfg.long_press_ms);
    assign debounce_inc  = (debounce_reg == 2'd3) ? debounce_reg : debounce_reg + 2'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        debounce_next = debounce_reg;
        hold_next     = hold_reg;
        click_next    = click_reg;
        gap_next      = gap_reg;
        ev            = bclp_pkg::EV_NONE;
        lrel          = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (act)
                begin
                    phase_next    = PH_DEBOUNCE;
                    debounce_next = 2'd0;
                end
                else if (click_reg != 8'd0)
                begin
                    gap_next = gap_inc;
                    if (gap_prod >= short_ext)
                    begin
                        if (click_reg == 8'd1)
                        begin
                            ev = bclp_pkg::EV_SINGLE;
                        end
                        else if (click_reg == 8'd2)
                        begin
                            ev = bclp_pkg::EV_DOUBLE;
                        end
                        else
                        begin
                            ev = bclp_pkg::EV_MULTI;
                        end
                        click_next = 8'd0;
                        gap_next   = '0;
                    end
                end
            end
            PH_DEBOUNCE:
            begin
                if (act)
                begin
                    debounce_next = debounce_inc;
                    if (debounce_inc >= DbLimit)
                    begin
                        phase_next = PH_PRESSED;
                        hold_next  = '0;
                        ev         = bclp_pkg::EV_DOWN;
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRESSED:
            begin
                if (!act)
                begin
                    phase_next = PH_RELEASE;
                    ev         = bclp_pkg::EV_UP;
                    if (held_prod < short_ext)
                    begin
                        if (click_reg != 8'hFF)
                        begin
                            click_next = click_reg + 8'd1;
                        end
                        gap_next = '0;
                    end
                    else if (held_prod >= long_ext)
                    begin
                        lrel       = 1'b1;
                        click_next = 8'd0;
                    end
                end
                else if (hold_reg == CntMax)
                begin
                    ev = bclp_pkg::EV_LHOLD;
                end
                else
                begin
                    hold_next = hold_reg + 1'b1;
                    if (held_inc_prod == long_ext)
                    begin
                        ev = bclp_pkg::EV_LSTART;
                    end
                    else if (held_inc_prod > long_ext)
                    begin
                        ev = bclp_pkg::EV_LHOLD;
                    end
                end
            end
            PH_RELEASE:
            begin
                if (act)
                begin
                    phase_next    = PH_DEBOUNCE;
                    debounce_next = 2'd0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase

        if (lrel)
        begin
            recent_next = bclp_pkg::EV_LUP;
        end
        else if (ev != bclp_pkg::EV_NONE)
        begin
            recent_next = ev;
        end
        else
        begin
            recent_next = recent_reg;
        end
    end

    assign result.event_code   = ev[2:0];
    assign result.long_release = lrel;
    assign result.last_event   = recent_next;
    assign result.level_seen   = level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            debounce_reg <= 2'd0;
            hold_reg     <= '0;
            click_reg    <= 8'd0;
            gap_reg      <= '0;
            recent_reg   <= bclp_pkg::EV_NONE;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            debounce_reg <= debounce_next;
            hold_reg     <= hold_next;
            click_reg    <= click_next;
            gap_reg      <= gap_next;
            recent_reg   <= recent_next;
        end
    end

endmodule

[hdl/bclp_out_reg.sv]
module bclp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  bclp_pkg::result_t result,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output bclp_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    bclp_pkg::result_t result_reg;
    bclp_pkg::result_t result_next;

    assign advance     = !valid_reg || out_ready;
    assign valid_next  = advance ? item_valid : valid_reg;
    assign result_next = (advance && item_valid) ? result : result_reg;
    assign out_valid   = valid_reg;
    assign out_result  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

[hdl/button_click_long_press_detector_unit.sv]
// Each accepted tick passes the input register, then the result register, where its result is
// presented until taken. Throughput: one tick per cycle while out_ready is high.
// The result register and input register decouple the sides, so a tick is taken while a
// finished result waits. Reset (rst_n low, asynchronous) clears the key state, the click
// and timing counters and the last event, and loads the register defaults.
module button_click_long_press_detector_unit #(
    parameter int unsigned ScanIntervalMs = bclp_pkg::SCAN_INTERVAL_MS,
    parameter int unsigned DebounceTicks  = bclp_pkg::DEBOUNCE_TICKS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bclp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bclp_pkg::MS_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           key_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     event_code,
    output logic                           long_release,
    output logic [3:0]                     last_event,
    output logic                           level_seen
);

    bclp_pkg::cfg_t    cfg;
    bclp_pkg::result_t result;
    bclp_pkg::result_t out_result;
    logic              advance;
    logic              item_valid;
    logic              item_level;

    bclp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bclp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_level  (key_level),
        .advance    (advance),
        .item_valid (item_valid),
        .item_level (item_level)
    );

    bclp_engine #(
        .ScanIntervalMs (ScanIntervalMs),
        .DebounceTicks  (DebounceTicks)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (item_valid && advance),
        .level  (item_level),
        .result (result)
    );

    bclp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign event_code   = out_result.event_code;
    assign long_release = out_result.long_release;
    assign last_event   = out_result.last_event;
    assign level_seen   = out_result.level_seen;

endmodule

[test/button_click_long_press_detector_unit_tb.sv]
`timescale 1ns / 1ps

module button_click_long_press_detector_unit_tb;

    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES   = 4;
    localparam int unsigned PHASE_TICKS     = 60;
    localparam int unsigned DIRECTED_ROWS   = 34;

    localparam logic [bclp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {KEY_IDLE, KEY_SETTLE, KEY_HELD, KEY_RELEASE} key_phase_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

    // A row is either a register write (count carries the data) or a run of
    // identical ticks; a pinned row is one tick whose result is typed in.
    typedef struct packed {
        logic                           is_reg;
        logic [bclp_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [bclp_pkg::MS_W-1:0]      count;
        logic                           level;
        logic                           pinned;
        bclp_pkg::result_t              res;
    } step_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bclp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bclp_pkg::MS_W-1:0]      cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic                           key_level;
    logic                           out_valid;
    logic                           out_ready;
    logic [2:0]                     event_code;
    logic                           long_release;
    logic [3:0]                     last_event;
    logic                           level_seen;

    key_phase_t  key_phase;
    logic [1:0]  settle_cnt;
    logic [15:0] press_span;
    logic [7:0]  tap_total;
    logic [15:0] gap_cnt;
    logic [3:0]  recent_ev;
    logic        cfg_active;
    logic [15:0] cfg_long;
    logic [15:0] cfg_short;

    bclp_pkg::result_t pending_results[$];
    bit                pin_en;
    bclp_pkg::result_t pin_res;
    bit                hold_req;
    int unsigned       burst_left;
    int unsigned       ticks_sent;
    int unsigned       fail_count;
    int unsigned       stuck_cycles;
    step_t             directed_steps [DIRECTED_ROWS];

    button_click_long_press_detector_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_level   (key_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code),
        .long_release(long_release),
        .last_event  (last_event),
        .level_seen  (level_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bclp_pkg::result_t predict_scan(input logic level);
        logic              pressed;
        int unsigned       span_ms;
        logic [3:0]        ev;
        logic              long_up;
        bclp_pkg::result_t r;
        pressed = (level == cfg_active);
        ev = bclp_pkg::EV_NONE;
        long_up = 1'b0;
        case (key_phase)
            KEY_IDLE:
            begin
                if (pressed)
                begin
                    key_phase = KEY_SETTLE;
                    settle_cnt = '0;
                end
                else if (tap_total != 0)
                begin
                    if (gap_cnt != 16'hFFFF)
                        gap_cnt++;
                    span_ms = gap_cnt * bclp_pkg::SCAN_INTERVAL_MS;
                    if (span_ms >= cfg_short)
                    begin
                        ev = (tap_total == 1) ? bclp_pkg::EV_SINGLE :
                             (tap_total == 2) ? bclp_pkg::EV_DOUBLE : bclp_pkg::EV_MULTI;
                        tap_total = '0;
                        gap_cnt = '0;
                    end
                end
            end
            KEY_SETTLE:
            begin
                if (pressed)
                begin
                    if (settle_cnt != 2'd3)
                        settle_cnt++;
                    if (settle_cnt >= bclp_pkg::DEBOUNCE_TICKS)
                    begin
                        key_phase = KEY_HELD;
                        press_span = '0;
                        ev = bclp_pkg::EV_DOWN;
                    end
                end
                else
                    key_phase = KEY_IDLE;
            end
            KEY_HELD:
            begin
                if (!pressed)
                begin
                    span_ms = press_span * bclp_pkg::SCAN_INTERVAL_MS;
                    key_phase = KEY_RELEASE;
                    ev = bclp_pkg::EV_UP;
                    if (span_ms < cfg_short)
                    begin
                        if (tap_total != 8'hFF)
                            tap_total++;
                        gap_cnt = '0;
                    end
                    else if (span_ms >= cfg_long)
                    begin
                        long_up = 1'b1;
                        tap_total = '0;
                    end
                end
                else if (press_span == 16'hFFFF)
                    ev = bclp_pkg::EV_LHOLD;
                else
                begin
                    press_span++;
                    span_ms = press_span * bclp_pkg::SCAN_INTERVAL_MS;
                    if (span_ms == cfg_long)
                        ev = bclp_pkg::EV_LSTART;
                    else if (span_ms > cfg_long)
                        ev = bclp_pkg::EV_LHOLD;
                end
            end
            default:
            begin
                if (pressed)
                begin
                    key_phase = KEY_SETTLE;
                    settle_cnt = '0;
                end
                else
                    key_phase = KEY_IDLE;
            end
        endcase
        if (long_up)
            recent_ev = bclp_pkg::EV_LUP;
        else if (ev != bclp_pkg::EV_NONE)
            recent_ev = ev;
        r.event_code = ev[2:0];
        r.long_release = long_up;
        r.last_event = recent_ev;
        r.level_seen = level;
        return r;
    endfunction

    function automatic step_t tick_row(input logic level, input int unsigned reps);
        step_t s;
        s = '0;
        s.level = level;
        s.count = bclp_pkg::MS_W'(reps);
        return s;
    endfunction

    function automatic step_t reg_row(input logic [bclp_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [bclp_pkg::MS_W-1:0] data);
        step_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.reg_idx = idx;
        s.count = data;
        return s;
    endfunction

    function automatic step_t pinned_row(input logic level, input bclp_pkg::result_t res);
        step_t s;
        s = '0;
        s.level = level;
        s.count = bclp_pkg::MS_W'(1);
        s.pinned = 1'b1;
        s.res = res;
        return s;
    endfunction

    task automatic compare_field(input string name, input logic [3:0] expected,
                                 input logic [3:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    task automatic send_tick(input logic level, input bit pinned = 1'b0,
                             input bclp_pkg::result_t res = '0);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        key_level = level;
        pin_en = pinned;
        pin_res = res;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic send_run(input logic level, input int unsigned reps);
        repeat (reps) send_tick(level);
    endtask

    // Registers change only with the block drained.
    task automatic write_reg(input logic [bclp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bclp_pkg::MS_W-1:0] data);
        in_valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(posedge clk)
    begin : monitor
        bclp_pkg::result_t predicted;
        bclp_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item arrived with no tick pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("event_code", 4'(want.event_code), 4'(event_code));
                    compare_field("long_release", 4'(want.long_release), 4'(long_release));
                    compare_field("last_event", want.last_event, last_event);
                    compare_field("level_seen", 4'(want.level_seen), 4'(level_seen));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bclp_pkg::CFG_PRESS_LEVEL:    cfg_active = cfg_data[0];
                    bclp_pkg::CFG_LONG_PRESS_MS:  cfg_long = cfg_data;
                    bclp_pkg::CFG_SHORT_PRESS_MS: cfg_short = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predicted = predict_scan(key_level);
                pending_results.push_back(pin_en ? pin_res : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned beat;
        out_ready = 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        beat = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            beat++;
            case (mode)
                RX_OPEN:   out_ready = 1'b1;
                RX_COIN:   out_ready = 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
                default:   out_ready = (beat % 3 != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        int unsigned short_ticks;
        int unsigned long_ticks;
        int unsigned hold_len;
        int unsigned phase_end;
        logic        act;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        key_level = 1'b0;
        pin_en = 1'b0;
        pin_res = '0;
        hold_req = 1'b0;
        burst_left = 0;
        ticks_sent = 0;
        fail_count = 0;
        stuck_cycles = 0;
        key_phase = KEY_IDLE;
        settle_cnt = '0;
        press_span = '0;
        tap_total = '0;
        gap_cnt = '0;
        recent_ev = bclp_pkg::EV_NONE;
        cfg_active = 1'b0;
        cfg_long = bclp_pkg::LONG_PRESS_MS_RST;
        cfg_short = bclp_pkg::SHORT_PRESS_MS_RST;

        directed_steps = '{
            pinned_row(1'b1, bclp_pkg::result_t'{3'(bclp_pkg::EV_NONE), 1'b0,
                                                 bclp_pkg::EV_NONE, 1'b1}),
            pinned_row(1'b0, bclp_pkg::result_t'{3'(bclp_pkg::EV_NONE), 1'b0,
                                                 bclp_pkg::EV_NONE, 1'b0}),
            tick_row(1'b1, 1),
            tick_row(1'b0, 3),
            tick_row(1'b1, 1),
            reg_row(bclp_pkg::CFG_LONG_PRESS_MS, 16'd50),
            reg_row(bclp_pkg::CFG_SHORT_PRESS_MS, 16'd20),
            tick_row(1'b1, 3),
            tick_row(1'b0, 9),
            pinned_row(1'b1, bclp_pkg::result_t'{3'(bclp_pkg::EV_UP), 1'b1,
                                                 bclp_pkg::EV_LUP, 1'b1}),
            tick_row(1'b0, 3),
            tick_row(1'b1, 1),
            tick_row(1'b0, 3),
            tick_row(1'b1, 4),
            tick_row(1'b0, 3),
            tick_row(1'b1, 2),
            tick_row(1'b0, 3),
            tick_row(1'b1, 2),
            tick_row(1'b0, 3),
            tick_row(1'b1, 4),
            tick_row(1'b0, 6),
            tick_row(1'b1, 2),
            reg_row(bclp_pkg::CFG_PRESS_LEVEL, 16'hFFFF),
            reg_row(bclp_pkg::CFG_LONG_PRESS_MS, 16'd0),
            reg_row(bclp_pkg::CFG_SHORT_PRESS_MS, 16'd0),
            tick_row(1'b1, 5),
            tick_row(1'b0, 2),
            reg_row(CFG_UNUSED, 16'h5A5A),
            reg_row(bclp_pkg::CFG_LONG_PRESS_MS, 16'd1),
            reg_row(bclp_pkg::CFG_SHORT_PRESS_MS, 16'd1),
            tick_row(1'b1, 3),
            tick_row(1'b0, 3),
            tick_row(1'b1, 4),
            tick_row(1'b0, 2)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_reg)
                write_reg(directed_steps[i].reg_idx, directed_steps[i].count);
            else if (directed_steps[i].pinned)
                send_tick(directed_steps[i].level, 1'b1, directed_steps[i].res);
            else
                send_run(directed_steps[i].level, directed_steps[i].count);
        end

        // Back-to-back short presses drive the click count into saturation,
        // then the gap timeout reports a multiple click.
        write_reg(bclp_pkg::CFG_SHORT_PRESS_MS, 16'd1);
        act = cfg_active;
        send_run(act, 3);
        repeat (257)
        begin
            send_run(!act, 1);
            send_run(act, 3);
        end
        send_run(!act, 3);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_reg(bclp_pkg::CFG_PRESS_LEVEL, bclp_pkg::MS_W'($urandom));
            write_reg(bclp_pkg::CFG_LONG_PRESS_MS, ($urandom_range(0, 1) == 0) ?
                      bclp_pkg::MS_W'(10 * $urandom_range(1, 30)) :
                      bclp_pkg::MS_W'($urandom_range(1, 300)));
            write_reg(bclp_pkg::CFG_SHORT_PRESS_MS, bclp_pkg::MS_W'($urandom_range(1, 150)));
            act = cfg_active;
            short_ticks = cfg_short / 10 + 1;
            long_ticks = cfg_long / 10 + 1;
            if (phase == 1)
                hold_req = 1'b1;
            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_run(act, $urandom_range(1, 2));
                        send_run(!act, 1);
                    end
                    case ($urandom_range(0, 2))
                        0:       hold_len = $urandom_range(0, short_ticks);
                        1:       hold_len = $urandom_range(short_ticks, long_ticks + 1);
                        default: hold_len = long_ticks + $urandom_range(0, 8);
                    endcase
                    send_run(act, 3 + hold_len);
                    send_run(!act, $urandom_range(1, short_ticks + 3));
                end
                else
                begin
                    repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
                end
            end
        end

        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[button_click_long_press_detector_unit.f]
hdl/bclp_pkg.sv
hdl/bclp_cfg_regs.sv
hdl/bclp_in_reg.sv
hdl/bclp_engine.sv
hdl/bclp_out_reg.sv
hdl/button_click_long_press_detector_unit.sv
test/button_click_long_press_detector_unit_tb.sv
